// ----- rtl/dfa_pkg.sv -----
`timescale 1ns / 1ps

package dfa_pkg;

  // field widths fixed by the item formats
  localparam int STATE_W  = 6;
  localparam int SYM_W    = 8;
  localparam int VISITS_W = 32;

  // parameter defaults
  localparam int NUM_STATES_DEF = 64;
  localparam int COUNT_BITS_DEF = 32;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_TRANS = 2'd0,
    KIND_MARK  = 2'd1,
    KIND_TEXT  = 2'd2,
    KIND_EOT   = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRANS,
    ST_ACC,
    ST_EOT
  } fsm_t;

  typedef struct packed {
    kind_t                kind;
    logic [STATE_W-1:0]   from_state;
    logic [SYM_W-1:0]     symbol;
    logic [STATE_W-1:0]   target_state;
    logic                 target_valid;
    logic                 accept_mark;
  } in_item_t;

  typedef struct packed {
    logic                 matched;
    logic [VISITS_W-1:0]  accept_visits;
  } out_item_t;

  // one transition table entry
  typedef struct packed {
    logic                 vld;
    logic [STATE_W-1:0]   nxt;
  } trans_ent_t;

  // table access requests from the sequencer
  typedef struct packed {
    logic                 trans_we;
    logic                 trans_re;
    logic [STATE_W-1:0]   trans_row;
    logic [SYM_W-1:0]     trans_sym;
    trans_ent_t           trans_wdata;
    logic                 acc_we;
    logic                 acc_re;
    logic [STATE_W-1:0]   acc_row;
    logic                 acc_wdata;
  } tbl_req_t;

endpackage

// ----- rtl/dfa_stream_matcher.sv -----
`timescale 1ns / 1ps

// Byte-stream matcher for a deterministic automaton held in on-chip tables.
// Input: an item is taken on a rising edge with start high and busy low.
//   Transition writes and accepting-mark writes are done as the item is
//   taken (busy stays low). A text byte takes a transition table read, then
//   an accepting-mark read of the new state, both on the single port of their
//   memory, each a registered read. A byte on a dead run, or one that kills
//   the run, skips the accepting-mark read. End of text takes one mark read.
// Output: end of text gives one result, with out_valid high for exactly one
//   cycle, registered from the ST_EOT state. Other kinds give no result.
//   The receiver cannot stall; results are not held.
// Configuration: cfg_data (start state) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is high while no item is in progress and
//   start is low. A write also re-arms the run at the new start state.
// Reset: rst_n low on a clock edge clears the sequencer, the start state,
//   the run (state 0, alive, count 0) and the output strobe. Table contents
//   are not cleared and must be loaded before text is sent.
module dfa_stream_matcher import dfa_pkg::*; #(
  parameter int NUM_STATES = NUM_STATES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  output logic               out_valid,
  output out_item_t          out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [STATE_W-1:0] cfg_data
);

  fsm_t                   state_r, state_nxt;
  logic [STATE_W-1:0]     start_r, start_nxt;
  logic [STATE_W-1:0]     cur_r, cur_nxt;
  logic                   dead_r, dead_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;
  tbl_req_t               req;
  trans_ent_t             trans_rd;
  logic                   acc_rd;
  logic                   cur_ok, from_ok, tgt_ok;

  dfa_tables #(
    .NUM_STATES (NUM_STATES)
  ) u_tables (
    .clk      (clk),
    .req      (req),
    .trans_rd (trans_rd),
    .acc_rd   (acc_rd)
  );

  assign cur_ok  = 32'(cur_r) < NUM_STATES;
  assign from_ok = 32'(in_item.from_state) < NUM_STATES;
  assign tgt_ok  = 32'(in_item.target_state) < NUM_STATES;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !start;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // sequencer: next state, table requests and run update
  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    dead_nxt      = dead_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    req           = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_item.kind)
            KIND_TRANS: begin
              req.trans_we        = from_ok;
              req.trans_row       = in_item.from_state;
              req.trans_sym       = in_item.symbol;
              req.trans_wdata.vld = in_item.target_valid & tgt_ok;
              req.trans_wdata.nxt = in_item.target_state;
            end
            KIND_MARK: begin
              req.acc_we    = from_ok;
              req.acc_row   = in_item.from_state;
              req.acc_wdata = in_item.accept_mark;
            end
            KIND_TEXT: begin
              req.trans_re  = 1'b1;
              req.trans_row = cur_r;
              req.trans_sym = in_item.symbol;
              state_nxt     = ST_TRANS;
            end
            KIND_EOT: begin
              req.acc_re  = 1'b1;
              req.acc_row = cur_r;
              state_nxt   = ST_EOT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // step on the transition just read, or kill the run
      ST_TRANS: begin
        if (dead_r) begin
          state_nxt = ST_IDLE;
        end else if (!cur_ok || !trans_rd.vld) begin
          dead_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cur_nxt     = trans_rd.nxt;
          req.acc_re  = 1'b1;
          req.acc_row = trans_rd.nxt;
          state_nxt   = ST_ACC;
        end
      end

      // count an arrival in an accepting state, saturating
      ST_ACC: begin
        if (acc_rd && (cnt_r != '1)) begin
          cnt_nxt = cnt_r + COUNT_BITS'(1);
        end
        state_nxt = ST_IDLE;
      end

      // issue the result and re-arm the run
      ST_EOT: begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.matched       = !dead_r && cur_ok && acc_rd;
        out_item_nxt.accept_visits = dead_r ? '0 : VISITS_W'(cnt_r);
        cur_nxt                    = start_r;
        dead_nxt                   = 1'b0;
        cnt_nxt                    = '0;
        state_nxt                  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // configuration transfer: new start state, re-arm
    if (cfg_valid && cfg_ready) begin
      start_nxt = cfg_data;
      cur_nxt   = cfg_data;
      dead_nxt  = 1'b0;
      cnt_nxt   = '0;
    end
  end

  // control and run registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      cur_r       <= '0;
      dead_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      cur_r       <= cur_nxt;
      dead_r      <= dead_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

// ----- rtl/dfa_tables.sv -----
`timescale 1ns / 1ps

module dfa_tables import dfa_pkg::*; #(
  parameter int NUM_STATES = NUM_STATES_DEF
) (
  input  logic       clk,
  input  tbl_req_t   req,
  output trans_ent_t trans_rd,
  output logic       acc_rd
);

  // rows beyond what a state field can name are never addressed
  localparam int ROWS   = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int DEPTH  = ROWS * (1 << SYM_W);
  localparam int ADDR_W = ROW_W + SYM_W;

  trans_ent_t        trans_mem [DEPTH];
  logic              acc_mem   [ROWS];
  trans_ent_t        trans_rd_r;
  logic              acc_rd_r;
  logic [ADDR_W-1:0] trans_addr;
  logic [ROW_W-1:0]  acc_addr;

  assign trans_addr = {req.trans_row[ROW_W-1:0], req.trans_sym};
  assign acc_addr   = req.acc_row[ROW_W-1:0];

  // transition table: one port, registered read
  always_ff @(posedge clk) begin
    if (req.trans_we) begin
      trans_mem[trans_addr] <= req.trans_wdata;
    end
    if (req.trans_re) begin
      trans_rd_r <= trans_mem[trans_addr];
    end
  end

  // accepting marks: one port, registered read
  always_ff @(posedge clk) begin
    if (req.acc_we) begin
      acc_mem[acc_addr] <= req.acc_wdata;
    end
    if (req.acc_re) begin
      acc_rd_r <= acc_mem[acc_addr];
    end
  end

  assign trans_rd = trans_rd_r;
  assign acc_rd   = acc_rd_r;

endmodule
